>>> rtl/core/ghrd_pkg.sv
// Package: types and constants shared by the gamepad report decoder.
`default_nettype none
package ghrd_pkg;

  localparam logic [7:0] IdSimple = 8'h3F;
  localparam logic [7:0] IdFull   = 8'h30;

  // positions are counted from zero; bytes two to nine are captured
  localparam logic [3:0] PosKind     = 4'd1;
  localparam logic [3:0] PosCapFirst = 4'd2;
  localparam logic [3:0] PosCapLast  = 4'd9;
  localparam logic [3:0] PosMax      = 4'd15;
  localparam logic [3:0] PosSimpleMin = 4'd9;   // last position of a 10-byte report
  localparam logic [3:0] PosFullMin   = 4'd12;  // last position of a 13-byte report

  localparam int unsigned CapDepth = 8;
  localparam int unsigned QDepth   = 2;

  localparam logic signed [15:0] AxisMax = 16'sh7FFF;
  localparam logic signed [15:0] AxisMin = 16'sh8000;
  localparam logic [7:0]         TrigOn  = 8'hFF;

  typedef enum logic [1:0] {
    RK_NONE,    // identifier not recognised
    RK_SHORT,   // recognised but too short to decode
    RK_SIMPLE,
    RK_FULL
  } rep_kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic              recognized;
    logic [15:0]       buttons;
    logic [7:0]        z_trigger;
    logic signed [15:0] left_stick_x;
    logic signed [15:0] left_stick_y;
    logic signed [15:0] right_stick_x;
    logic signed [15:0] right_stick_y;
  } out_item_t;

  typedef logic [CapDepth-1:0][7:0] cap_bytes_t;

  // one finished report, as handed from front to back
  typedef struct packed {
    rep_kind_e  kind;
    cap_bytes_t bytes;
  } rec_t;

endpackage
`default_nettype wire

>>> rtl/core/ghrd_front.sv
// Front end: counts report bytes, captures the payload and classifies the report.
`default_nettype none
module ghrd_front import ghrd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_item_t in_data_i,
  input  wire logic     q_full_i,
  output logic          push_o,
  output rec_t          push_rec_o
);

  logic [3:0] pos_q, pos_d;
  logic [7:0] kind_q, kind_d;
  cap_bytes_t cap_q;
  cap_bytes_t cap_merged;
  logic       accept;
  logic       cap_en;
  logic [2:0] cap_idx;
  logic [7:0] kind_eff;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  assign cap_en  = (pos_q >= PosCapFirst) && (pos_q <= PosCapLast);
  assign cap_idx = 3'(pos_q - PosCapFirst);

  // view the store as it stands once this byte is written
  always_comb begin
    cap_merged = cap_q;
    if (cap_en) begin
      cap_merged[cap_idx] = in_data_i.data_byte;
    end
  end

  assign kind_eff = (pos_q == PosKind) ? in_data_i.data_byte : kind_q;

  always_comb begin
    pos_d  = pos_q;
    kind_d = kind_q;
    if (accept) begin
      if (pos_q == PosKind) begin
        kind_d = in_data_i.data_byte;
      end
      if (pos_q != PosMax) begin
        pos_d = pos_q + 4'd1;
      end
      if (in_data_i.last_byte) begin
        pos_d  = '0;
        kind_d = '0;
      end
    end
  end

  always_comb begin
    push_o           = accept & in_data_i.last_byte;
    push_rec_o.bytes = cap_merged;
    if (kind_eff == IdSimple) begin
      push_rec_o.kind = (pos_q >= PosSimpleMin) ? RK_SIMPLE : RK_SHORT;
    end else if (kind_eff == IdFull) begin
      push_rec_o.kind = (pos_q >= PosFullMin) ? RK_FULL : RK_SHORT;
    end else begin
      push_rec_o.kind = RK_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      kind_q <= '0;
    end else begin
      pos_q  <= pos_d;
      kind_q <= kind_d;
    end
  end

  // payload store, no reset
  always_ff @(posedge clk_i) begin
    if (accept && cap_en) begin
      cap_q[cap_idx] <= in_data_i.data_byte;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ghrd_queue.sv
// Short report queue between the front and back ends.
`default_nettype none
module ghrd_queue import ghrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire rec_t push_rec_i,
  output logic      full_o,
  output logic      not_empty_o,
  input  wire logic pop_i,
  output rec_t      head_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  rec_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o      = (cnt_q == CntW'(QDepth));
  assign not_empty_o = (cnt_q != '0);
  assign head_o      = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/ghrd_back.sv
// Back end: decodes a queued report into buttons and axes, with an output register.
`default_nettype none
module ghrd_back import ghrd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic q_not_empty_i,
  input  wire rec_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_item_t out_data_o
);

  logic      out_valid_q;
  out_item_t out_data_q, dec;

  assign pop_o = q_not_empty_i & (~out_valid_q | ~out_stall_i);

  always_comb begin
    logic [7:0]  b1, b2, hat, r, m, l;
    logic [11:0] x, y;
    b1  = head_i.bytes[0];
    b2  = head_i.bytes[1];
    hat = head_i.bytes[2];
    r   = head_i.bytes[2];
    m   = head_i.bytes[3];
    l   = head_i.bytes[4];
    x   = {head_i.bytes[6][3:0], head_i.bytes[5]};
    y   = {head_i.bytes[7], head_i.bytes[6][7:4]};
    dec = '0;
    case (head_i.kind)
      RK_SHORT: begin
        dec.recognized = 1'b1;
      end
      RK_SIMPLE: begin
        dec.recognized  = 1'b1;
        dec.buttons[12] = b1[1];
        dec.buttons[13] = b1[0];
        dec.buttons[4]  = b2[1];
        dec.buttons[8]  = b1[4];
        dec.buttons[9]  = b1[5];
        if (b1[6]) dec.z_trigger = TrigOn;
        // later assignment wins on each axis
        if (b1[2]) dec.right_stick_y = AxisMax;
        if (b1[7]) dec.right_stick_y = AxisMin;
        if (b1[3]) dec.right_stick_x = AxisMin;
        if (b2[0]) dec.right_stick_x = AxisMax;
        if (hat[7:3] == 5'd0) begin
          dec.buttons[0] = (hat[2:0] == 3'd7) || (hat[2:0] == 3'd0) || (hat[2:0] == 3'd1);
          dec.buttons[1] = (hat[2:0] == 3'd3) || (hat[2:0] == 3'd4) || (hat[2:0] == 3'd5);
          dec.buttons[2] = (hat[2:0] == 3'd5) || (hat[2:0] == 3'd6) || (hat[2:0] == 3'd7);
          dec.buttons[3] = (hat[2:0] == 3'd1) || (hat[2:0] == 3'd2) || (hat[2:0] == 3'd3);
        end
        dec.left_stick_x = {head_i.bytes[4] ^ 8'h80, 8'h00};
        dec.left_stick_y = {8'd127 - head_i.bytes[6], 8'h00};
      end
      RK_FULL: begin
        dec.recognized  = 1'b1;
        dec.buttons[12] = r[3];
        dec.buttons[13] = r[2];
        dec.buttons[4]  = m[1] | m[4];
        dec.buttons[5]  = m[5];
        dec.buttons[8]  = l[6];
        dec.buttons[9]  = r[6];
        dec.buttons[0]  = l[1];
        dec.buttons[1]  = l[0];
        dec.buttons[2]  = l[3];
        dec.buttons[3]  = l[2];
        if (l[7]) dec.z_trigger = TrigOn;
        if (r[0]) dec.right_stick_y = AxisMax;
        if (r[7]) dec.right_stick_y = AxisMin;
        if (r[1]) dec.right_stick_x = AxisMin;
        if (m[0]) dec.right_stick_x = AxisMax;
        // re-centre the 12-bit value and scale to 16 bits
        dec.left_stick_x = {~x[11], x[10:0], 4'h0};
        dec.left_stick_y = {~y[11], y[10:0], 4'h0};
      end
      default: begin
        dec = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= dec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
`default_nettype wire

>>> rtl/core/gamepad_hid_report_decoder.sv
// Gamepad report decoder: top level joining front end, report queue and back end.
//
// Input channel: one report byte per transaction (in_valid_i / in_stall_o,
// payload in_data_i); last_byte marks the final byte of a report. Byte one is
// the report identifier (simple or full format). Output channel: one decoded
// result per report (out_valid_o / out_stall_i, payload out_data_o).
// Throughput: one byte per cycle while in_stall_o is low. The edge that takes
// the last byte of a report writes it into the queue; the back end then decodes
// the queue head into its output register, which drives out_valid_o.
// Stall: while the receiver stalls, the result holds in the output register
// and up to two finished reports wait in the queue; the input keeps taking
// bytes until the queue is full, then in_stall_o rises.
// Reset: byte counter, identifier, queue and output valid clear; the captured
// payload bytes are not cleared and need none, as each decode reads only
// bytes written by its own report.
`default_nettype none
module gamepad_hid_report_decoder import ghrd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_data_o
);

  logic q_full, q_not_empty, push, pop;
  rec_t push_rec, head;

  ghrd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  ghrd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rec_i  (push_rec),
    .full_o      (q_full),
    .not_empty_o (q_not_empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  ghrd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .head_i        (head),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_data_o    (out_data_o)
  );

endmodule
`default_nettype wire

>>> rtl/core/ghrd_checker.sv
// Checker on the decoder's ports, bound to the top level.
`default_nettype none
module ghrd_checker import ghrd_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_data_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_o
);

  // hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input transaction changed");

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_unrec_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.recognized |->
      out_data_o.buttons == '0 && out_data_o.z_trigger == '0 &&
      out_data_o.left_stick_x == '0 && out_data_o.left_stick_y == '0 &&
      out_data_o.right_stick_x == '0 && out_data_o.right_stick_y == '0)
    else $error("unrecognised report carries data");

  a_rx_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.right_stick_x == '0 || out_data_o.right_stick_x == AxisMax ||
      out_data_o.right_stick_x == AxisMin)
    else $error("right stick x off its three levels");

  a_trig_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.z_trigger == '0 || out_data_o.z_trigger == TrigOn)
    else $error("trigger neither off nor full");

endmodule

bind gamepad_hid_report_decoder ghrd_checker u_ghrd_checker (.*);
`default_nettype wire

>>> test/ghrd_checker.sv
// Checker for the gamepad report decoder: tracks each report, predicts its result and compares.
`timescale 1ns / 100ps
module ghrd_scoreboard import ghrd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_stall_i,
  input  wire in_item_t  in_data_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_stall_i,
  input  wire out_item_t out_data_i,
  output int             fail_count_o,
  output int             pending_o
);

  // bit positions in the button word
  localparam int BitUp    = 0;
  localparam int BitDown  = 1;
  localparam int BitLeft  = 2;
  localparam int BitRight = 3;
  localparam int BitStart = 4;
  localparam int BitBack  = 5;
  localparam int BitLsh   = 8;
  localparam int BitRsh   = 9;
  localparam int BitA     = 12;
  localparam int BitB     = 13;

  logic [3:0] byte_pos;
  logic [7:0] rep_ident;
  cap_bytes_t payload;
  out_item_t  decoded_q[$];
  int         mismatches;

  function automatic out_item_t decode_report(input logic [7:0] id, input logic [3:0] end_pos);
    out_item_t  res;
    logic [7:0] b1, b2, hat, rb, mb, lb;
    logic [11:0] x12, y12;
    res = '0;
    if (id == IdSimple) begin
      res.recognized = 1'b1;
      if (end_pos >= PosSimpleMin) begin
        b1  = payload[0];
        b2  = payload[1];
        hat = payload[2];
        res.buttons[BitA]     = b1[1];
        res.buttons[BitB]     = b1[0];
        res.buttons[BitStart] = b2[1];
        res.buttons[BitLsh]   = b1[4];
        res.buttons[BitRsh]   = b1[5];
        if (b1[6]) res.z_trigger = TrigOn;
        // later C-button wins on each axis
        if (b1[2]) res.right_stick_y = AxisMax;
        if (b1[7]) res.right_stick_y = AxisMin;
        if (b1[3]) res.right_stick_x = AxisMin;
        if (b2[0]) res.right_stick_x = AxisMax;
        case (hat)
          8'd0: res.buttons[BitUp] = 1'b1;
          8'd1: begin
            res.buttons[BitUp]    = 1'b1;
            res.buttons[BitRight] = 1'b1;
          end
          8'd2: res.buttons[BitRight] = 1'b1;
          8'd3: begin
            res.buttons[BitDown]  = 1'b1;
            res.buttons[BitRight] = 1'b1;
          end
          8'd4: res.buttons[BitDown] = 1'b1;
          8'd5: begin
            res.buttons[BitDown] = 1'b1;
            res.buttons[BitLeft] = 1'b1;
          end
          8'd6: res.buttons[BitLeft] = 1'b1;
          8'd7: begin
            res.buttons[BitUp]   = 1'b1;
            res.buttons[BitLeft] = 1'b1;
          end
          default: ;
        endcase
        res.left_stick_x = ({8'h00, payload[4]} - 16'd128) << 8;
        res.left_stick_y = (16'd127 - {8'h00, payload[6]}) << 8;
      end
    end else if (id == IdFull) begin
      res.recognized = 1'b1;
      if (end_pos >= PosFullMin) begin
        rb = payload[2];
        mb = payload[3];
        lb = payload[4];
        res.buttons[BitA]     = rb[3];
        res.buttons[BitB]     = rb[2];
        res.buttons[BitStart] = mb[1] | mb[4];
        res.buttons[BitBack]  = mb[5];
        res.buttons[BitLsh]   = lb[6];
        res.buttons[BitRsh]   = rb[6];
        res.buttons[BitUp]    = lb[1];
        res.buttons[BitDown]  = lb[0];
        res.buttons[BitLeft]  = lb[3];
        res.buttons[BitRight] = lb[2];
        if (lb[7]) res.z_trigger = TrigOn;
        if (rb[0]) res.right_stick_y = AxisMax;
        if (rb[7]) res.right_stick_y = AxisMin;
        if (rb[1]) res.right_stick_x = AxisMin;
        if (mb[0]) res.right_stick_x = AxisMax;
        // two 12-bit axes packed into three bytes
        x12 = {payload[6][3:0], payload[5]};
        y12 = {payload[7], payload[6][7:4]};
        res.left_stick_x = ({4'h0, x12} - 16'd2048) << 4;
        res.left_stick_y = ({4'h0, y12} - 16'd2048) << 4;
      end
    end
    return res;
  endfunction

  task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (decoded_q.size() == 0) begin
      $display("%0t: result with none expected, got %h", $time, got);
      mismatches++;
    end else begin
      want = decoded_q.pop_front();
      compare_field("recognized", 16'(want.recognized), 16'(got.recognized));
      compare_field("buttons", want.buttons, got.buttons);
      compare_field("z_trigger", 16'(want.z_trigger), 16'(got.z_trigger));
      compare_field("left_stick_x", want.left_stick_x, got.left_stick_x);
      compare_field("left_stick_y", want.left_stick_y, got.left_stick_y);
      compare_field("right_stick_x", want.right_stick_x, got.right_stick_x);
      compare_field("right_stick_y", want.right_stick_y, got.right_stick_y);
    end
  endtask

  task automatic take_byte(input in_item_t it);
    logic [3:0] pos;
    pos = byte_pos;
    if (pos == PosKind) begin
      rep_ident = it.data_byte;
    end else if (pos >= PosCapFirst && pos <= PosCapLast) begin
      payload[3'(pos - PosCapFirst)] = it.data_byte;
    end
    if (byte_pos < PosMax) byte_pos++;
    if (it.last_byte) begin
      decoded_q.push_back(decode_report(rep_ident, pos));
      // rearm for the next report
      byte_pos  = '0;
      rep_ident = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos     = '0;
      rep_ident    = '0;
      payload      = '0;
      mismatches   = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      if (in_valid_i && !in_stall_i) take_byte(in_data_i);
      pending_o    <= decoded_q.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

>>> test/tb.sv
// Testbench top: drives report bytes and receiver stalls, and gives the verdict.
`timescale 1ns / 100ps
module tb;
  import ghrd_pkg::*;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  in_item_t  in_data_i   = '0;
  logic      out_stall_i = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_item_t out_data_o;

  int fail_count;
  int pending;
  int bytes_sent  = 0;
  int burst_left  = 0;
  int hold_reqs   = 0;
  int reports     = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  gamepad_hid_report_decoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  ghrd_scoreboard u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // offer one byte and hold it until the transaction completes
  task automatic put_byte(input logic [7:0] d, input logic last);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: d, last_byte: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  // fill: 0 random content, 1 all zeros, 2 all ones
  task automatic send_report(input logic [7:0] id, input int len, input int fill);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      if (i == PosKind) d = id;
      else if (fill == 1) d = 8'h00;
      else if (fill == 2) d = 8'hFF;
      else if (id == IdSimple && i == 4 && $urandom_range(0, 3) != 0) d = 8'($urandom_range(0, 8));
      else d = 8'($urandom_range(0, 255));
      put_byte(d, i == len - 1);
    end
    reports++;
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // receiver: changing stall patterns, plus long hold-offs on request
  initial begin : rx_stall
    int seen, mode, run;
    seen = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_reqs != seen) begin
        seen = hold_reqs;
        out_stall_i <= 1'b1;
        repeat (150) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        run  = (mode == 2) ? $urandom_range(1, 6) : $urandom_range(1, 40);
        for (int i = 0; i < run; i++) begin
          case (mode)
            0:       out_stall_i <= 1'b0;
            1:       out_stall_i <= 1'($urandom_range(0, 1));
            2:       out_stall_i <= 1'b1;
            default: out_stall_i <= ($urandom_range(0, 3) == 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    int pick, minlen, len, fill;
    logic [7:0] id;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // report ending before its identifier, a short simple report,
    // then a simple report of all ones and a full report of all zeros
    send_report(8'($urandom_range(0, 255)), 1, 0);
    send_report(IdSimple, 2, 0);
    send_report(IdSimple, 10, 2);
    send_report(IdFull, 13, 1);
    wait_drained();

    while (bytes_sent < 800) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) id = IdSimple;
      else if (pick < 8) id = IdFull;
      else id = 8'($urandom_range(0, 255));
      minlen = (id == IdFull) ? 13 : 10;
      pick = $urandom_range(0, 9);
      if (pick < 2) len = $urandom_range(1, minlen - 1);
      else if (pick == 2) len = $urandom_range(14, 24);
      else len = minlen + $urandom_range(0, 2);
      pick = $urandom_range(0, 9);
      fill = (pick == 0) ? 1 : (pick == 1) ? 2 : 0;
      send_report(id, len, fill);
      if (reports == 15 || reports == 50) hold_reqs <= hold_reqs + 1;
      if (reports == 35) wait_drained();
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
